/* rtl/pps_pkg.sv */
package pps_pkg;

	// CORDIC datapath sizing
	localparam int CORDIC_STEPS = 30;
	localparam int CW = 60;
	localparam int ZW = 34;

	typedef logic signed [23:0] pos_t;
	typedef logic signed [15:0] head_t;
	typedef logic signed [31:0] speed_t;
	typedef logic [9:0] idx_t;

	typedef enum logic [1:0] {
		MODE_WAYPOINT,
		MODE_POSE,
		MODE_SPEED,
		MODE_JOY
	} mode_t;

	typedef enum logic [2:0] {
		REG_LOOKAHEAD,
		REG_WHEEL_BASE,
		REG_SPEED_FLOOR,
		REG_SPEED_CEIL,
		REG_COOLDOWN,
		REG_STOP_STEER,
		REG_STOP_SPEED
	} cfg_reg_t;

	// binary angles, 2^32 per turn
	localparam logic signed [ZW-1:0] ANG_PI = 34'sh0_8000_0000;
	localparam logic signed [ZW-1:0] ANG_HALF_PI = 34'sh0_4000_0000;
	localparam logic signed [CW-1:0] INV_GAIN_Q30 = 60'sd652032874;

	// steering scale: degrees*2.2 in 2^-32, then onto 0.2..0.8 of full scale
	localparam logic signed [44:0] DEG_LIMIT = 45'sd193273528320;
	localparam logic signed [44:0] STEER_BIAS = 45'sd322122547200;
	localparam logic [23:0] RECIP_150 = 24'd14316558;

	function automatic logic [29:0] atan_step(input logic [4:0] i);
		logic [29:0] r;
		case (i)
			5'd0: r = 30'h20000000;
			5'd1: r = 30'h12E4051E;
			5'd2: r = 30'h09FB385B;
			5'd3: r = 30'h051111D4;
			5'd4: r = 30'h028B0D43;
			5'd5: r = 30'h0145D7E1;
			5'd6: r = 30'h00A2F61E;
			5'd7: r = 30'h00517C55;
			5'd8: r = 30'h0028BE53;
			5'd9: r = 30'h00145F2F;
			5'd10: r = 30'h000A2F98;
			5'd11: r = 30'h000517CC;
			5'd12: r = 30'h00028BE6;
			5'd13: r = 30'h000145F3;
			5'd14: r = 30'h0000A2FA;
			5'd15: r = 30'h0000517D;
			5'd16: r = 30'h000028BE;
			5'd17: r = 30'h0000145F;
			5'd18: r = 30'h00000A30;
			5'd19: r = 30'h00000518;
			5'd20: r = 30'h0000028C;
			5'd21: r = 30'h00000146;
			5'd22: r = 30'h000000A3;
			5'd23: r = 30'h00000051;
			5'd24: r = 30'h00000029;
			5'd25: r = 30'h00000014;
			5'd26: r = 30'h0000000A;
			5'd27: r = 30'h00000005;
			5'd28: r = 30'h00000003;
			5'd29: r = 30'h00000001;
			default: r = 30'h0;
		endcase
		return r;
	endfunction

	// bearing minus heading, folded into [-pi/2, pi/2] for the sine
	function automatic logic signed [ZW-1:0] fold_angle(input logic [31:0] phi,
			input logic [15:0] head);
		logic [31:0] a32;
		logic signed [ZW-1:0] a;
		a32 = phi - {head, 16'h0000};
		a = ZW'(signed'(a32));
		if (a > ANG_HALF_PI) begin
			a = ANG_PI - a;
		end else if (a < -ANG_HALF_PI) begin
			a = -ANG_PI - a;
		end
		return a;
	endfunction

endpackage

/* rtl/pps_if.sv */
interface pps_item_if;
	import pps_pkg::*;
	logic valid;
	logic ready;
	mode_t mode;
	pos_t pos_x;
	pos_t pos_y;
	head_t heading;
	idx_t point_index;
	logic last_point;
	speed_t speed_value;
	logic button_pressed;
	logic [3:0] axes_count;
	logic [31:0] time_ms;
	modport source (output valid, mode, pos_x, pos_y, heading, point_index, last_point,
		speed_value, button_pressed, axes_count, time_ms, input ready);
	modport sink (input valid, mode, pos_x, pos_y, heading, point_index, last_point,
		speed_value, button_pressed, axes_count, time_ms, output ready);
endinterface

interface pps_result_if;
	import pps_pkg::*;
	logic valid;
	logic ready;
	logic [15:0] steer_cmd;
	speed_t speed_cmd;
	idx_t target_index;
	logic autonomous;
	modport source (output valid, steer_cmd, speed_cmd, target_index, autonomous,
		input ready);
	modport sink (input valid, steer_cmd, speed_cmd, target_index, autonomous,
		output ready);
endinterface

interface pps_cfg_if;
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/pure_pursuit_steering.sv */
// channel | dir | payload                                         | transfer
// item    | in  | mode, pos_x/y, heading, point_index, last_point, | valid & ready
//         |     | speed_value, button_pressed, axes_count, time_ms |
// result  | out | steer_cmd, speed_cmd, target_index, autonomous   | valid & ready
// cfg     | in  | index, data                                      | valid & ready
//
// A pose item makes two passes over the waypoint memory at one read a cycle (nearest
// point, then lookahead search), then three 30-step CORDIC runs and a 32-step square
// root on one shared datapath. Reset is asynchronous; the waypoint memory is not
// cleared. A result waits in the output register; the next item is taken meanwhile,
// and only a further result stalls until the register is free.
module pure_pursuit_steering #(
	parameter int PATH_DEPTH = 1024
) (
	input logic clk,
	input logic arst_n,
	pps_item_if.sink item,
	pps_result_if.source result,
	pps_cfg_if.sink cfg
);
	import pps_pkg::*;

	localparam int AW = (PATH_DEPTH > 2) ? $clog2(PATH_DEPTH) : 1;
	localparam int LW = AW + 1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SPEED, ST_SCAN, ST_VSET, ST_CORDIC, ST_SQRT, ST_MUL,
		ST_SCALE, ST_DIV1, ST_DIV2, ST_PUSH
	} state_t;

	typedef enum logic [1:0] {
		CP_PHI, CP_SIN, CP_THETA
	} cph_t;

	state_t state_q;
	cph_t cph_q;

	// configuration
	logic [15:0] la_q;
	logic [11:0] wb_q;
	logic signed [31:0] sfloor_q, sceil_q, sspeed_q;
	logic [15:0] cool_q, ssteer_q;

	// block state
	logic [LW-1:0] path_len_q;
	logic auto_q;
	logic signed [31:0] dspeed_q;
	logic [31:0] last_tog_q;

	// pose context
	logic signed [23:0] px_q, py_q;
	logic [15:0] head_q;
	logic [31:0] lim_q;

	// scan pipeline
	logic pass_q;
	logic [LW-1:0] iss_q;
	logic v_s1, v_s2, v_s3;
	logic [AW-1:0] idx_s1, idx_s2, idx_s3;
	logic signed [24:0] dx_s2, dy_s2, dx_s3, dy_s3;
	logic [48:0] sqx_s3, sqy_s3;
	logic [49:0] best_q;
	logic [AW-1:0] near_q, tgt_q;
	logic signed [24:0] tdx_q, tdy_q;
	logic [49:0] tdsq_q;

	// waypoint memory
	logic [47:0] wp_mem [PATH_DEPTH];
	logic [47:0] rdata_q;

	// shared CORDIC and root units
	logic signed [CW-1:0] cx_q, cy_q;
	logic signed [ZW-1:0] cz_q;
	logic [4:0] it_q;
	logic [63:0] sv_q, sres_q, sbit_q;
	logic signed [31:0] sn_q;
	logic signed [44:0] num_q, s_q;
	logic [30:0] ld_q;
	logic [47:0] dprod_q;
	logic signed [41:0] prod_q;

	// pending and output results
	logic [15:0] res_steer_q, out_steer_q;
	logic signed [31:0] res_speed_q, out_speed_q;
	logic [9:0] res_tgt_q, out_tgt_q;
	logic res_auto_q, out_auto_q, out_valid_q;

	logic acc;
	logic [31:0] idx32;
	logic wr_en, issue_en;
	logic signed [23:0] rd_x, rd_y;
	logic signed [24:0] dx_n, dy_n;
	logic [49:0] d_s3;
	logic last_s3, hit_s3;
	logic restart_s3, done_s3;
	logic [AW-1:0] near_nx;
	logic [31:0] elapsed;
	logic tog, auto_nx;
	logic signed [CW-1:0] xs, ys, cx_n, cy_n;
	logic signed [ZW-1:0] tab, cz_n;
	logic up, cord_last;
	logic signed [CW-1:0] vin_x, vin_y, vs_x, vs_y;
	logic signed [ZW-1:0] vs_z;
	logic vs_zero;
	logic [63:0] sq_t, sres_n;
	logic signed [13:0] wb2;
	logic signed [44:0] s_clamp, s_biased;

	assign acc = item.valid && item.ready;
	assign item.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign idx32 = {22'd0, item.point_index};
	assign wr_en = acc && (item.mode == MODE_WAYPOINT) && (idx32 < 32'(PATH_DEPTH));
	assign issue_en = (state_q == ST_SCAN) && (iss_q < path_len_q);

	assign result.valid = out_valid_q;
	assign result.steer_cmd = out_steer_q;
	assign result.speed_cmd = out_speed_q;
	assign result.target_index = out_tgt_q;
	assign result.autonomous = out_auto_q;

	// waypoint memory: one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			wp_mem[idx32[AW-1:0]] <= {item.pos_x, item.pos_y};
		end
		if (issue_en) begin
			rdata_q <= wp_mem[iss_q[AW-1:0]];
		end
	end

	// scan stage arithmetic
	always_comb begin
		rd_x = signed'(rdata_q[47:24]);
		rd_y = signed'(rdata_q[23:0]);
		dx_n = {rd_x[23], rd_x} - {px_q[23], px_q};
		dy_n = {rd_y[23], rd_y} - {py_q[23], py_q};
		d_s3 = {1'b0, sqx_s3} + {1'b0, sqy_s3};
		last_s3 = ({1'b0, idx_s3} == (path_len_q - LW'(1)));
		hit_s3 = d_s3 > 50'(lim_q);
		near_nx = (v_s3 && (d_s3 < best_q)) ? idx_s3 : near_q;
		restart_s3 = v_s3 && !pass_q && last_s3;
		done_s3 = v_s3 && pass_q && (hit_s3 || last_s3);
	end

	// joystick toggle
	always_comb begin
		elapsed = item.time_ms - last_tog_q;
		tog = item.button_pressed && (elapsed > {16'd0, cool_q});
		auto_nx = auto_q ^ tog;
	end

	// one CORDIC micro-rotation
	always_comb begin
		xs = cx_q >>> it_q;
		ys = cy_q >>> it_q;
		tab = ZW'(atan_step(it_q));
		up = (cph_q == CP_SIN) ? cz_q[ZW-1] : !cy_q[CW-1];
		cx_n = up ? (cx_q + ys) : (cx_q - ys);
		cy_n = up ? (cy_q - xs) : (cy_q + xs);
		cz_n = up ? (cz_q + tab) : (cz_q - tab);
		cord_last = (it_q == 5'(CORDIC_STEPS - 1));
	end

	// vectoring setup: left half plane turned by pi
	always_comb begin
		if (cph_q == CP_THETA) begin
			vin_x = {5'd0, ld_q, 24'd0};
			vin_y = {{15{num_q[44]}}, num_q};
		end else begin
			vin_x = {{5{tdx_q[24]}}, tdx_q, 30'd0};
			vin_y = {{5{tdy_q[24]}}, tdy_q, 30'd0};
		end
		vs_zero = (vin_x == '0) && (vin_y == '0);
		if (vin_x[CW-1]) begin
			vs_x = -vin_x;
			vs_y = -vin_y;
			vs_z = vin_y[CW-1] ? -ANG_PI : ANG_PI;
		end else begin
			vs_x = vin_x;
			vs_y = vin_y;
			vs_z = '0;
		end
	end

	// root step, clamp and scaling
	always_comb begin
		sq_t = sres_q + sbit_q;
		sres_n = (sv_q >= sq_t) ? ((sres_q >> 1) + sbit_q) : (sres_q >> 1);
		wb2 = signed'({1'b0, wb_q, 1'b0});
		if (s_q > DEG_LIMIT) begin
			s_clamp = DEG_LIMIT;
		end else if (s_q < -DEG_LIMIT) begin
			s_clamp = -DEG_LIMIT;
		end else begin
			s_clamp = s_q;
		end
		s_biased = s_clamp + STEER_BIAS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cph_q <= CP_PHI;
			la_q <= 16'd2048;
			wb_q <= 12'd338;
			sfloor_q <= -32'sd327680;
			sceil_q <= 32'sd655360;
			cool_q <= 16'd500;
			ssteer_q <= 16'd32768;
			sspeed_q <= '0;
			path_len_q <= '0;
			auto_q <= 1'b0;
			dspeed_q <= '0;
			last_tog_q <= '0;
			px_q <= '0;
			py_q <= '0;
			head_q <= '0;
			lim_q <= '0;
			pass_q <= 1'b0;
			iss_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			idx_s1 <= '0;
			idx_s2 <= '0;
			idx_s3 <= '0;
			dx_s2 <= '0;
			dy_s2 <= '0;
			dx_s3 <= '0;
			dy_s3 <= '0;
			sqx_s3 <= '0;
			sqy_s3 <= '0;
			best_q <= '0;
			near_q <= '0;
			tgt_q <= '0;
			tdx_q <= '0;
			tdy_q <= '0;
			tdsq_q <= '0;
			cx_q <= '0;
			cy_q <= '0;
			cz_q <= '0;
			it_q <= '0;
			sv_q <= '0;
			sres_q <= '0;
			sbit_q <= '0;
			sn_q <= '0;
			num_q <= '0;
			s_q <= '0;
			ld_q <= '0;
			dprod_q <= '0;
			prod_q <= '0;
			res_steer_q <= '0;
			res_speed_q <= '0;
			res_tgt_q <= '0;
			res_auto_q <= 1'b0;
			out_steer_q <= '0;
			out_speed_q <= '0;
			out_tgt_q <= '0;
			out_auto_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// configuration writes
			if (cfg.valid) begin
				unique case (cfg_reg_t'(cfg.index))
					REG_LOOKAHEAD: la_q <= cfg.data[15:0];
					REG_WHEEL_BASE: wb_q <= cfg.data[11:0];
					REG_SPEED_FLOOR: sfloor_q <= signed'(cfg.data);
					REG_SPEED_CEIL: sceil_q <= signed'(cfg.data);
					REG_COOLDOWN: cool_q <= cfg.data[15:0];
					REG_STOP_STEER: ssteer_q <= cfg.data[15:0];
					REG_STOP_SPEED: sspeed_q <= signed'(cfg.data);
					default: ;
				endcase
			end

			// drop the output once taken, unless a new result replaces it
			if (result.ready && (state_q != ST_PUSH)) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						unique case (item.mode)
							MODE_WAYPOINT: begin
								if (wr_en && item.last_point) begin
									path_len_q <= LW'(idx32 + 32'd1);
								end
							end
							MODE_SPEED: begin
								prod_q <= 42'(item.speed_value) * 42'sd1000;
								state_q <= ST_SPEED;
							end
							MODE_JOY: begin
								if (tog) begin
									auto_q <= auto_nx;
									last_tog_q <= item.time_ms;
								end
								if (!auto_nx && (item.axes_count >= 4'd3)) begin
									res_steer_q <= ssteer_q;
									res_speed_q <= sspeed_q;
									res_tgt_q <= '0;
									res_auto_q <= 1'b0;
									state_q <= ST_PUSH;
								end
							end
							MODE_POSE: begin
								px_q <= item.pos_x;
								py_q <= item.pos_y;
								head_q <= item.heading;
								lim_q <= 32'(la_q) * 32'(la_q);
								best_q <= '1;
								near_q <= '0;
								pass_q <= 1'b0;
								iss_q <= '0;
								v_s1 <= 1'b0;
								v_s2 <= 1'b0;
								v_s3 <= 1'b0;
								if ((path_len_q != '0) && auto_q) begin
									state_q <= ST_SCAN;
								end
							end
							default: ;
						endcase
					end
				end

				ST_SPEED: begin
					// when the limits cross, values below the floor get the floor and all others the ceiling
					if (prod_q < 42'(sfloor_q)) begin
						dspeed_q <= sfloor_q;
					end else if (prod_q > 42'(sceil_q)) begin
						dspeed_q <= sceil_q;
					end else begin
						dspeed_q <= signed'(prod_q[31:0]);
					end
					state_q <= ST_IDLE;
				end

				ST_SCAN: begin
					// advance the difference and square stages
					idx_s1 <= iss_q[AW-1:0];
					idx_s2 <= idx_s1;
					dx_s2 <= dx_n;
					dy_s2 <= dy_n;
					idx_s3 <= idx_s2;
					dx_s3 <= dx_s2;
					dy_s3 <= dy_s2;
					sqx_s3 <= 49'(dx_s2 * dx_s2);
					sqy_s3 <= 49'(dy_s2 * dy_s2);
					if (v_s3 && !pass_q) begin
						if (d_s3 < best_q) begin
							best_q <= d_s3;
						end
						near_q <= near_nx;
					end
					if (restart_s3) begin
						// restart the reads from the nearest point
						pass_q <= 1'b1;
						iss_q <= {1'b0, near_nx};
						v_s1 <= 1'b0;
						v_s2 <= 1'b0;
						v_s3 <= 1'b0;
					end else if (done_s3) begin
						tgt_q <= idx_s3;
						tdx_q <= dx_s3;
						tdy_q <= dy_s3;
						tdsq_q <= d_s3;
						v_s1 <= 1'b0;
						v_s2 <= 1'b0;
						v_s3 <= 1'b0;
						cph_q <= CP_PHI;
						state_q <= ST_VSET;
					end else begin
						iss_q <= iss_q + LW'(issue_en);
						v_s1 <= issue_en;
						v_s2 <= v_s1;
						v_s3 <= v_s2;
					end
				end

				ST_VSET: begin
					it_q <= '0;
					if (vs_zero) begin
						if (cph_q == CP_THETA) begin
							cz_q <= '0;
							state_q <= ST_SCALE;
						end else begin
							cx_q <= INV_GAIN_Q30;
							cy_q <= '0;
							cz_q <= fold_angle(32'd0, head_q);
							cph_q <= CP_SIN;
							state_q <= ST_CORDIC;
						end
					end else begin
						cx_q <= vs_x;
						cy_q <= vs_y;
						cz_q <= vs_z;
						state_q <= ST_CORDIC;
					end
				end

				ST_CORDIC: begin
					if (cord_last) begin
						it_q <= '0;
						unique case (cph_q)
							CP_PHI: begin
								cx_q <= INV_GAIN_Q30;
								cy_q <= '0;
								cz_q <= fold_angle(cz_n[31:0], head_q);
								cph_q <= CP_SIN;
							end
							CP_SIN: begin
								sn_q <= signed'(cy_n[31:0]);
								sv_q <= {2'd0, tdsq_q, 12'd0};
								sres_q <= '0;
								sbit_q <= 64'h4000_0000_0000_0000;
								state_q <= ST_SQRT;
							end
							CP_THETA: begin
								cz_q <= cz_n;
								state_q <= ST_SCALE;
							end
							default: ;
						endcase
					end else begin
						cx_q <= cx_n;
						cy_q <= cy_n;
						cz_q <= cz_n;
						it_q <= it_q + 5'd1;
					end
				end

				ST_SQRT: begin
					if (sv_q >= sq_t) begin
						sv_q <= sv_q - sq_t;
					end
					sres_q <= sres_n;
					sbit_q <= sbit_q >> 2;
					if (sbit_q[0]) begin
						ld_q <= sres_n[30:0];
						state_q <= ST_MUL;
					end
				end

				ST_MUL: begin
					num_q <= 45'(wb2) * 45'(sn_q);
					cph_q <= CP_THETA;
					state_q <= ST_VSET;
				end

				ST_SCALE: begin
					s_q <= 45'(cz_q) * 45'sd792;
					state_q <= ST_DIV1;
				end

				ST_DIV1: begin
					// divide by 150*2^16: shift, add half of 150, then reciprocal of 150
					dprod_q <= 48'(s_biased[39:16] + 24'd75) * 48'(RECIP_150);
					state_q <= ST_DIV2;
				end

				ST_DIV2: begin
					res_steer_q <= dprod_q[46:31];
					res_speed_q <= dspeed_q;
					res_tgt_q <= 10'(tgt_q);
					res_auto_q <= 1'b1;
					state_q <= ST_PUSH;
				end

				ST_PUSH: begin
					// hold until the output register is free
					if (!out_valid_q || result.ready) begin
						out_steer_q <= res_steer_q;
						out_speed_q <= res_speed_q;
						out_tgt_q <= res_tgt_q;
						out_auto_q <= res_auto_q;
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* verif/tb_top.sv */
module tb_top;
	import pps_pkg::*;

	localparam int TABLE_SLOTS = 1024;
	localparam int IDLE_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 2500;
	localparam longint TURN_HALF = 64'sd2147483648;
	localparam longint TURN_QUARTER = 64'sd1073741824;
	localparam longint GAIN_INV = 64'sd652032874;
	localparam longint CLAMP_DEG = 64'sd193273528320;
	localparam longint SERVO_LOW = 64'sd128849018880;
	localparam longint SERVO_ROUND = 64'sd4915200;
	localparam longint SERVO_STEP = 64'sd9830400;
	localparam logic [29:0] ARC_LUT [30] = '{
		30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43, 30'h0145D7E1,
		30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F, 30'h000A2F98, 30'h000517CC,
		30'h00028BE6, 30'h000145F3, 30'h0000A2FA, 30'h0000517D, 30'h000028BE, 30'h0000145F,
		30'h00000A30, 30'h00000518, 30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051,
		30'h00000029, 30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000003, 30'h00000001
	};

	typedef struct {
		mode_t mode;
		pos_t x;
		pos_t y;
		head_t hd;
		idx_t pidx;
		logic last;
		speed_t spd;
		logic btn;
		logic [3:0] axes;
		logic [31:0] tms;
	} cmd_t;

	typedef struct {
		logic [15:0] steer;
		speed_t speed;
		idx_t tgt;
		logic auto_on;
	} drive_t;

	// tracks path, mode and limits; queues the commands each transaction should produce
	class steer_scoreboard;
		longint wp_x [TABLE_SLOTS];
		longint wp_y [TABLE_SLOTS];
		int path_len;
		bit auto_on;
		longint desired;
		logic [31:0] last_toggle;
		longint look, wbase, floor_spd, ceil_spd, cool, stop_st, stop_sp;
		drive_t pending [$];
		int errors;

		function new();
			path_len = 0;
			auto_on = 0;
			desired = 0;
			last_toggle = 0;
			look = 2048;
			wbase = 338;
			floor_spd = -327680;
			ceil_spd = 655360;
			cool = 500;
			stop_st = 32768;
			stop_sp = 0;
			errors = 0;
		endfunction

		function void write_reg(cfg_reg_t r, logic [31:0] d);
			case (r)
				REG_LOOKAHEAD: look = d[15:0];
				REG_WHEEL_BASE: wbase = d[11:0];
				REG_SPEED_FLOOR: floor_spd = longint'(signed'(d));
				REG_SPEED_CEIL: ceil_spd = longint'(signed'(d));
				REG_COOLDOWN: cool = d[15:0];
				REG_STOP_STEER: stop_st = d[15:0];
				REG_STOP_SPEED: stop_sp = longint'(signed'(d));
				default: ;
			endcase
		endfunction

		function longint vec_atan(longint y, longint x);
			longint z, xs, ys;
			z = 0;
			if (x == 0 && y == 0) return 0;
			if (x < 0) begin
				z = (y >= 0) ? TURN_HALF : -TURN_HALF;
				x = -x;
				y = -y;
			end
			for (int i = 0; i < 30; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y >= 0) begin
					x += ys; y -= xs; z += longint'(ARC_LUT[i]);
				end else begin
					x -= ys; y += xs; z -= longint'(ARC_LUT[i]);
				end
			end
			return z;
		endfunction

		function longint rot_sin(longint a);
			longint x, y, xs, ys;
			x = GAIN_INV;
			y = 0;
			if (a > TURN_QUARTER) a = TURN_HALF - a;
			else if (a < -TURN_QUARTER) a = -TURN_HALF - a;
			for (int i = 0; i < 30; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (a >= 0) begin
					x -= ys; y += xs; a -= longint'(ARC_LUT[i]);
				end else begin
					x += ys; y -= xs; a += longint'(ARC_LUT[i]);
				end
			end
			return y;
		endfunction

		function longint unsigned root(longint unsigned v);
			longint unsigned res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > v) b >>= 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v -= res + b;
					res = (res >> 1) + b;
				end else begin
					res >>= 1;
				end
				b >>= 2;
			end
			return res;
		endfunction

		function longint unsigned dsq(int i, longint px, longint py);
			longint dx, dy;
			dx = wp_x[i] - px;
			dy = wp_y[i] - py;
			return longint'(dx * dx) + longint'(dy * dy);
		endfunction

		function logic [15:0] servo_of(longint px, longint py, head_t hd, int tgt);
			longint dx, dy, phi, alpha, sn, num, theta, s;
			longint unsigned ld;
			logic [31:0] au;
			dx = wp_x[tgt] - px;
			dy = wp_y[tgt] - py;
			phi = vec_atan(dy * 64'sd1073741824, dx * 64'sd1073741824);
			au = phi[31:0] - {hd, 16'h0000};
			alpha = longint'(signed'(au));
			sn = rot_sin(alpha);
			ld = root((longint'(dx * dx) + longint'(dy * dy)) << 12);
			num = 2 * wbase * sn;
			theta = vec_atan(num, longint'(ld << 24));
			s = theta * 792;
			if (s > CLAMP_DEG) s = CLAMP_DEG;
			if (s < -CLAMP_DEG) s = -CLAMP_DEG;
			s = (s + CLAMP_DEG + SERVO_LOW + SERVO_ROUND) / SERVO_STEP;
			return s[15:0];
		endfunction

		function void note(cmd_t c);
			longint v, px, py;
			longint unsigned best, d, lim;
			logic [31:0] gap;
			int near, tgt;
			drive_t r;
			px = c.x;
			py = c.y;
			case (c.mode)
				MODE_WAYPOINT: begin
					wp_x[c.pidx] = px;
					wp_y[c.pidx] = py;
					if (c.last) path_len = int'(c.pidx) + 1;
				end
				MODE_SPEED: begin
					v = longint'(c.spd) * 1000;
					// when the limits cross, values below the floor get the floor and all others the ceiling
					if (v < floor_spd) v = floor_spd;
					else if (v > ceil_spd) v = ceil_spd;
					desired = v;
				end
				MODE_JOY: begin
					gap = c.tms - last_toggle;
					if (c.btn && longint'(gap) > cool) begin
						auto_on = !auto_on;
						last_toggle = c.tms;
					end
					if (!auto_on && c.axes >= 3) begin
						r.steer = stop_st[15:0];
						r.speed = stop_sp[31:0];
						r.tgt = '0;
						r.auto_on = 1'b0;
						pending.push_back(r);
					end
				end
				default: begin
					if (path_len == 0 || !auto_on) return;
					best = '1;
					near = 0;
					for (int i = 0; i < path_len; i++) begin
						d = dsq(i, px, py);
						if (d < best) begin
							best = d;
							near = i;
						end
					end
					lim = look * look;
					tgt = path_len - 1;
					for (int i = near; i < path_len; i++) begin
						if (dsq(i, px, py) > lim) begin
							tgt = i;
							break;
						end
					end
					r.steer = servo_of(px, py, c.hd, tgt);
					r.speed = desired[31:0];
					r.tgt = tgt[9:0];
					r.auto_on = 1'b1;
					pending.push_back(r);
				end
			endcase
		endfunction

		function void check(drive_t got);
			drive_t want;
			if (pending.size() == 0) begin
				$error("unexpected result transaction steer=%0d", got.steer);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.steer !== want.steer) begin
				$error("steer_cmd expected %0d actual %0d", want.steer, got.steer);
				errors++;
			end
			if (got.speed !== want.speed) begin
				$error("speed_cmd expected %0d actual %0d", want.speed, got.speed);
				errors++;
			end
			if (got.tgt !== want.tgt) begin
				$error("target_index expected %0d actual %0d", want.tgt, got.tgt);
				errors++;
			end
			if (got.auto_on !== want.auto_on) begin
				$error("autonomous expected %0d actual %0d", want.auto_on, got.auto_on);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	pps_item_if item_ch ();
	pps_result_if res_ch ();
	pps_cfg_if cfg_ch ();

	pure_pursuit_steering dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch.sink),
		.result(res_ch.source),
		.cfg(cfg_ch.sink)
	);

	steer_scoreboard sb;
	bit written [TABLE_SLOTS];
	int prefix;
	int burst_left;
	int idle_cycles;
	logic [31:0] now_ms;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// receiver stall pattern: switches between four random ready styles
	int stall_style;
	int stall_run;
	int stall_tick;
	always @(negedge clk) begin
		stall_tick++;
		if (stall_tick % 64 == 0) stall_style = $urandom_range(0, 3);
		case (stall_style)
			0: res_ch.ready = 1'b1;
			1: res_ch.ready = stall_tick[0];
			2: res_ch.ready = ($urandom_range(0, 2) != 0);
			default: begin
				if (stall_run > 0) begin
					stall_run--;
					res_ch.ready = 1'b0;
				end else begin
					res_ch.ready = 1'b1;
					if ($urandom_range(0, 3) == 0) stall_run = $urandom_range(1, 20);
				end
			end
		endcase
	end

	// check results and watch for a hang
	always @(posedge clk) begin
		drive_t got;
		if (res_ch.valid && res_ch.ready) begin
			got.steer = res_ch.steer_cmd;
			got.speed = res_ch.speed_cmd;
			got.tgt = res_ch.target_index;
			got.auto_on = res_ch.autonomous;
			sb.check(got);
		end
		if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("pure_pursuit_steering verification failed");
			$finish;
		end
	end

	task automatic send(cmd_t c);
		if (burst_left == 0) begin
			item_ch.valid = 1'b0;
			repeat ($urandom_range(1, 30)) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		item_ch.mode = c.mode;
		item_ch.pos_x = c.x;
		item_ch.pos_y = c.y;
		item_ch.heading = c.hd;
		item_ch.point_index = c.pidx;
		item_ch.last_point = c.last;
		item_ch.speed_value = c.spd;
		item_ch.button_pressed = c.btn;
		item_ch.axes_count = c.axes;
		item_ch.time_ms = c.tms;
		item_ch.valid = 1'b1;
		do @(posedge clk); while (!item_ch.ready);
		sb.note(c);
		if (c.mode == MODE_WAYPOINT) begin
			written[c.pidx] = 1'b1;
			while (prefix < TABLE_SLOTS && written[prefix]) prefix++;
		end
		@(negedge clk);
	endtask

	task automatic write_cfg(cfg_reg_t r, logic [31:0] d);
		cfg_ch.index = r;
		cfg_ch.data = d;
		cfg_ch.valid = 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		sb.write_reg(r, d);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// hold the sender until every queued result has arrived
	task automatic drain();
		item_ch.valid = 1'b0;
		burst_left = 0;
		while (sb.pending.size() != 0) @(negedge clk);
	endtask

	function automatic cmd_t blank(mode_t m);
		cmd_t c;
		c.mode = m;
		c.x = '0;
		c.y = '0;
		c.hd = '0;
		c.pidx = '0;
		c.last = 1'b0;
		c.spd = '0;
		c.btn = 1'b0;
		c.axes = 4'd3;
		c.tms = '0;
		return c;
	endfunction

	function automatic cmd_t wp(int i, int x, int y, bit last);
		cmd_t c;
		c = blank(MODE_WAYPOINT);
		c.pidx = i[9:0];
		c.x = x[23:0];
		c.y = y[23:0];
		c.last = last;
		return c;
	endfunction

	function automatic cmd_t pose(int x, int y, int h);
		cmd_t c;
		c = blank(MODE_POSE);
		c.x = x[23:0];
		c.y = y[23:0];
		c.hd = h[15:0];
		return c;
	endfunction

	function automatic cmd_t joy(bit b, int axes, logic [31:0] t);
		cmd_t c;
		c = blank(MODE_JOY);
		c.btn = b;
		c.axes = axes[3:0];
		c.tms = t;
		return c;
	endfunction

	function automatic cmd_t spd(logic [31:0] v);
		cmd_t c;
		c = blank(MODE_SPEED);
		c.spd = v;
		return c;
	endfunction

	function automatic cmd_t rand_cmd();
		cmd_t c;
		int pick, i, lim;
		pick = $urandom_range(0, 99);
		if (pick < 20) begin
			// mostly extend or rework the path, sometimes a stray slot
			lim = (prefix < 47) ? prefix : 47;
			i = ($urandom_range(0, 9) == 0) ? $urandom_range(0, TABLE_SLOTS - 1)
				: $urandom_range(0, lim);
			c = blank(MODE_WAYPOINT);
			c.pidx = i[9:0];
			if ($urandom_range(0, 9) == 0) begin
				c.x = 24'($urandom());
				c.y = 24'($urandom());
			end else begin
				c.x = 24'(i * 1500 + $urandom_range(0, 2000) - 1000);
				c.y = 24'($urandom_range(0, 6000) - 3000);
			end
			c.last = (i < prefix || i == prefix && i < TABLE_SLOTS) ?
				($urandom_range(0, 3) == 0) : 1'b0;
		end else if (pick < 30) begin
			c = blank(MODE_SPEED);
			c.spd = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 2000) - 1000;
		end else if (pick < 50) begin
			now_ms = ($urandom_range(0, 19) == 0) ? $urandom() : now_ms + $urandom_range(0, 900);
			c = joy($urandom_range(0, 7) == 0, $urandom_range(0, 15), now_ms);
			c.x = 24'($urandom());
			c.y = 24'($urandom());
		end else begin
			c = blank(MODE_POSE);
			i = $urandom_range(0, 47);
			if ($urandom_range(0, 9) == 0) begin
				c.x = 24'($urandom());
				c.y = 24'($urandom());
			end else begin
				c.x = 24'(i * 1500 + $urandom_range(0, 8000) - 4000);
				c.y = 24'($urandom_range(0, 8000) - 4000);
			end
			c.hd = 16'($urandom());
		end
		return c;
	endfunction

	initial begin
		cfg_reg_t r;
		logic [31:0] d;
		sb = new();
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.mode = MODE_WAYPOINT;
		item_ch.pos_x = '0;
		item_ch.pos_y = '0;
		item_ch.heading = '0;
		item_ch.point_index = '0;
		item_ch.last_point = 1'b0;
		item_ch.speed_value = '0;
		item_ch.button_pressed = 1'b0;
		item_ch.axes_count = '0;
		item_ch.time_ms = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_LOOKAHEAD;
		cfg_ch.data = '0;
		res_ch.ready = 1'b0;
		stall_style = 0;
		stall_run = 0;
		stall_tick = 0;
		idle_cycles = 0;
		prefix = 0;
		burst_left = 0;
		now_ms = 32'd4000;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty path, idle stops, toggling, extremes, standing on the target
		send(pose(0, 0, 0));
		send(joy(1'b0, 3, 32'd100));
		send(joy(1'b0, 2, 32'd200));
		send(wp(0, 0, 0, 1'b0));
		send(wp(1, 2048, 0, 1'b0));
		send(wp(2, 4096, 1024, 1'b0));
		send(wp(3, 8388607, -8388608, 1'b1));
		send(wp(1023, -8388608, 8388607, 1'b0));
		send(spd(32'd1));
		send(joy(1'b1, 15, 32'd1000));
		send(joy(1'b1, 0, 32'd1200));
		send(pose(0, 0, 0));
		send(pose(4096, 1024, -32768));
		send(pose(-8388608, 8388607, 32767));
		send(spd(32'h8000_0000));
		send(pose(8388607, -8388608, 16384));
		send(spd(32'd100));
		send(pose(2048, 0, -16384));
		send(joy(1'b1, 3, 32'd2000));
		send(pose(0, 0, 0));
		send(joy(1'b1, 3, 32'hFFFF_FFFF));
		send(pose(100, -100, 1));
		drain();

		// random phases, each under a different register setting
		for (int ph = 0; ph < 5; ph++) begin
			repeat (SETTLE_CYCLES) @(negedge clk);
			for (int k = 0; k < 7; k++) begin
				r = cfg_reg_t'(k);
				case (ph)
					0: d = (k == 0) ? 32'd0 : (k == 1) ? 32'd4095 : (k == 2) ? 32'h8000_0000 :
						(k == 3) ? 32'h7FFF_FFFF : (k == 4) ? 32'd0 : (k == 5) ? 32'd0 :
						32'h8000_0000;
					1: d = (k == 0) ? 32'd65535 : (k == 1) ? 32'd0 : (k == 2) ? 32'd500000 :
						(k == 3) ? 32'd100000 : (k == 4) ? 32'd65535 : (k == 5) ? 32'hFFFF :
						32'h7FFF_FFFF;
					default: d = (k == 2 || k == 3 || k == 6) ? $urandom()
						: $urandom_range(0, (k == 1) ? 4095 : (k == 0) ? 6000 : 65535);
				endcase
				if (ph >= 2 && k == 2) d = -$urandom_range(0, 2000000);
				if (ph >= 2 && k == 3) d = $urandom_range(0, 2000000);
				if (ph >= 2 && k == 4) d = $urandom_range(0, 1000);
				write_cfg(r, d);
			end
			@(negedge clk);
			for (int n = 0; n < 52; n++) send(rand_cmd());
			drain();
		end

		repeat (SETTLE_CYCLES) @(negedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("pure_pursuit_steering verification clean");
		else
			$display("pure_pursuit_steering verification failed");
		$finish;
	end

endmodule
